// ===== rtl/core/sme_pkg.sv =====
// Shared types and constants of the stack machine executor.
package sme_pkg;

    typedef logic [31:0] word_t;
    typedef logic [6:0]  cmd_code_t;
    typedef logic [2:0]  status_t;

    localparam cmd_code_t OP_PUSH  = 7'd1;
    localparam cmd_code_t OP_ADD   = 7'd2;
    localparam cmd_code_t OP_SUB   = 7'd3;
    localparam cmd_code_t OP_MUL   = 7'd4;
    localparam cmd_code_t OP_DIV   = 7'd5;
    localparam cmd_code_t OP_PEEK  = 7'd6;
    localparam cmd_code_t OP_HALT  = 7'd7;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_HALTED    = 3'd1;
    localparam status_t ST_OVERFLOW  = 3'd2;
    localparam status_t ST_UNDERFLOW = 3'd3;
    localparam status_t ST_DIVZERO   = 3'd4;
    localparam status_t ST_UNKNOWN   = 3'd5;

    typedef enum logic [1:0] {
        EXE_IDLE,
        EXE_READ,
        EXE_DIV
    } exe_state_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } sme_div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
    } sme_div_rsp_t;

endpackage

// ===== rtl/core/sme_div.sv =====
// Iterative signed divider that truncates toward zero, one quotient bit per cycle.
module sme_div (
    input  logic               clk,
    input  logic               rst_n,
    input  sme_pkg::sme_div_req_t req,
    output sme_pkg::sme_div_rsp_t rsp
);
    import sme_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    word_t       rem_reg, rem_next;
    word_t       quo_reg, quo_next;
    word_t       den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[31]};
        diff      = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
            den_next  = req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
            neg_next  = req.dividend[31] ^ req.divisor[31];
        end
        else if (busy_reg)
        begin
            rem_next = diff[32] ? shifted[31:0] : diff[31:0];
            quo_next = {quo_reg[30:0], ~diff[32]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + 32'd1) : quo_reg;

endmodule

// ===== rtl/core/stack_machine_executor_core.sv =====
// Top level of the stack machine executor: control, stack memory and result register.
//
//  Channel   Handshake                 Payload
//  instr     instr_valid/instr_stall   cmd, operand, end_of_program
//  res       res_valid/res_stall       top_value, stack_depth, status, print_strobe, done_res
//
// Push, print, halt, unknown opcodes and ignored instructions finish straight from the idle state.
// Add, subtract and multiply pass through the read state, waiting on the registered stack memory read.
// Divide passes through the read state and then the divide state, where the 32-step bit-serial divider runs.
// The top of stack sits in a register; the words below it live in the stack memory.
// Reset empties the stack and clears the halt and error state; the memory is not cleared.
// A new instruction is taken once the previous one is finished and the result slot is free.
module stack_machine_executor_core #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  instr_valid,
    output logic                  instr_stall,
    input  sme_pkg::cmd_code_t    cmd,
    input  logic signed [31:0]    operand,
    input  logic                  end_of_program,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic signed [31:0]    top_value,
    output logic [8:0]            stack_depth,
    output sme_pkg::status_t      status,
    output logic                  print_strobe,
    output logic                  done_res
);
    import sme_pkg::*;

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    word_t stack_mem [STACK_DEPTH];

    exe_state_t      state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    word_t           tos_reg, tos_next;
    logic            halt_reg, halt_next;
    status_t         err_reg, err_next;
    cmd_code_t       op_reg, op_next;
    logic            eop_reg, eop_next;

    logic            res_valid_reg, res_valid_next;
    word_t           top_reg, top_next;
    logic [8:0]      depth_reg, depth_next;
    status_t         status_reg, status_next;
    logic            print_reg, print_next;
    logic            done_reg, done_next;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    word_t             rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [SP_W-1:0] sp_m1;
    logic [SP_W-1:0] sp_m2;
    logic            accept;
    logic            stopped;
    logic            finish;
    logic [SP_W-1:0] fin_sp;
    word_t           fin_tos;
    logic            fin_halt;
    status_t         fin_err;
    logic            fin_print;
    logic            fin_eop;
    word_t           opnd_a;

    sme_div_req_t div_req;
    sme_div_rsp_t div_rsp;

    sme_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sp_m1       = sp_reg - SP_W'(1);
    assign sp_m2       = sp_reg - SP_W'(2);
    assign instr_stall = (state_reg != EXE_IDLE) || (res_valid_reg && res_stall);
    assign accept      = instr_valid && !instr_stall;
    assign stopped     = halt_reg || (err_reg != ST_OK);
    assign opnd_a      = rd_data_reg;
    assign wr_addr     = sp_m1[ADDR_W-1:0];
    assign rd_addr     = sp_m2[ADDR_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        eop_next         = eop_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = opnd_a;
        div_req.divisor  = tos_reg;
        finish           = 1'b0;
        fin_sp           = sp_reg;
        fin_tos          = tos_reg;
        fin_halt         = halt_reg;
        fin_err          = err_reg;
        fin_print        = 1'b0;
        fin_eop          = eop_reg;

        unique case (state_reg)
            EXE_IDLE:
            begin
                if (accept)
                begin
                    eop_next = end_of_program;
                    fin_eop  = end_of_program;
                    finish   = 1'b1;
                    if (!stopped)
                    begin
                        unique case (cmd) inside
                            OP_PUSH:
                            begin
                                if (sp_reg == SP_W'(STACK_DEPTH))
                                begin
                                    fin_err = ST_OVERFLOW;
                                end
                                else
                                begin
                                    wr_en   = (sp_reg != '0);
                                    fin_tos = word_t'(operand);
                                    fin_sp  = sp_reg + SP_W'(1);
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                            begin
                                if (sp_reg < SP_W'(2))
                                begin
                                    fin_err = ST_UNDERFLOW;
                                end
                                else if ((cmd == OP_DIV) && (tos_reg == '0))
                                begin
                                    fin_err = ST_DIVZERO;
                                end
                                else
                                begin
                                    finish     = 1'b0;
                                    rd_en      = 1'b1;
                                    op_next    = cmd;
                                    state_next = EXE_READ;
                                end
                            end
                            OP_PEEK:
                            begin
                                if (sp_reg == '0)
                                begin
                                    fin_err = ST_UNDERFLOW;
                                end
                                else
                                begin
                                    fin_print = 1'b1;
                                end
                            end
                            OP_HALT:
                            begin
                                fin_halt = 1'b1;
                            end
                            default:
                            begin
                                fin_err = ST_UNKNOWN;
                            end
                        endcase
                    end
                end
            end
            EXE_READ:
            begin
                fin_sp = sp_m1;
                finish = 1'b1;
                state_next = EXE_IDLE;
                case (op_reg)
                    OP_ADD:  fin_tos = opnd_a + tos_reg;
                    OP_SUB:  fin_tos = opnd_a - tos_reg;
                    OP_MUL:  fin_tos = opnd_a * tos_reg;
                    default:
                    begin
                        fin_sp        = sp_reg;
                        finish        = 1'b0;
                        div_req.start = 1'b1;
                        state_next    = EXE_DIV;
                    end
                endcase
            end
            EXE_DIV:
            begin
                if (div_rsp.done)
                begin
                    fin_sp     = sp_m1;
                    fin_tos    = div_rsp.quotient;
                    finish     = 1'b1;
                    state_next = EXE_IDLE;
                end
            end
            default:
            begin
                state_next = EXE_IDLE;
            end
        endcase

        sp_next        = sp_reg;
        tos_next       = tos_reg;
        halt_next      = halt_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg && res_stall;
        top_next       = top_reg;
        depth_next     = depth_reg;
        status_next    = status_reg;
        print_next     = print_reg;
        done_next      = done_reg;

        if (finish)
        begin
            res_valid_next = 1'b1;
            top_next       = (fin_sp != '0) ? fin_tos : '0;
            depth_next     = 9'(fin_sp);
            print_next     = fin_print;
            done_next      = fin_eop;
            if (fin_err != ST_OK)
            begin
                status_next = fin_err;
            end
            else if (fin_eop && (fin_sp == '0))
            begin
                status_next = ST_UNDERFLOW;
            end
            else if (fin_halt)
            begin
                status_next = ST_HALTED;
            end
            else
            begin
                status_next = ST_OK;
            end
            tos_next  = fin_tos;
            sp_next   = fin_eop ? '0 : fin_sp;
            halt_next = fin_eop ? 1'b0 : fin_halt;
            err_next  = fin_eop ? ST_OK : fin_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EXE_IDLE;
            sp_reg        <= '0;
            halt_reg      <= 1'b0;
            err_reg       <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            halt_reg      <= halt_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg    <= tos_next;
        op_reg     <= op_next;
        eop_reg    <= eop_next;
        top_reg    <= top_next;
        depth_reg  <= depth_next;
        status_reg <= status_next;
        print_reg  <= print_next;
        done_reg   <= done_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= tos_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign res_valid    = res_valid_reg;
    assign top_value    = $signed(top_reg);
    assign stack_depth  = depth_reg;
    assign status       = status_reg;
    assign print_strobe = print_reg;
    assign done_res     = done_reg;

endmodule

// ===== rtl/core/sme_checker.sv =====
// Port-level checks of the stack machine executor and their binding to the top level.
module sme_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_stall,
    input logic signed [31:0] top_value,
    input logic [8:0]         stack_depth,
    input sme_pkg::status_t   status,
    input logic               print_strobe,
    input logic               done_res
);
    import sme_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(top_value) && $stable(status))
        else $error("Stalled result changed before its transfer.");

    a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && print_strobe |-> (status == ST_OK) && (stack_depth != 9'd0))
        else $error("Print strobe on a result without a valid top.");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (stack_depth == 9'd0) |-> (top_value == 32'sd0))
        else $error("Empty stack reported a nonzero top.");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res && (stack_depth == 9'd0)
            |-> (status != ST_OK) && (status != ST_HALTED))
        else $error("Program ended on an empty stack without an error status.");

endmodule

bind stack_machine_executor_core sme_checker u_sme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .top_value    (top_value),
    .stack_depth  (stack_depth),
    .status       (status),
    .print_strobe (print_strobe),
    .done_res     (done_res)
);

// ===== tb/sv/testbench.sv =====
// Testbench for the stack machine executor: directed and random programs checked by an in-bench model.
module testbench;
    import sme_pkg::*;

    localparam int          STACK_WORDS  = 256;
    localparam int          RANDOM_ITEMS = 860;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          PRINT_LIMIT  = 40;

    localparam word_t     WORD_MIN  = 32'h8000_0000;
    localparam word_t     WORD_MAX  = 32'h7fff_ffff;
    localparam word_t     WORD_NEG1 = 32'hffff_ffff;
    localparam cmd_code_t OP_NONE   = 7'd0;
    localparam cmd_code_t OP_LAST   = 7'd127;

    typedef struct {
        word_t      top;
        logic [8:0] depth;
        status_t    code;
        logic       printed;
        logic       done;
    } exec_result_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               instr_valid    = 1'b0;
    logic               instr_stall;
    cmd_code_t          cmd            = OP_NONE;
    logic signed [31:0] operand        = '0;
    logic               end_of_program = 1'b0;
    logic               res_valid;
    logic               res_stall      = 1'b0;
    logic signed [31:0] top_value;
    logic [8:0]         stack_depth;
    status_t            status;
    logic               print_strobe;
    logic               done_res;

    word_t        stack_mem [STACK_WORDS];
    int unsigned  sp_model      = 0;
    bit           halted_model  = 1'b0;
    status_t      err_model     = ST_OK;
    exec_result_t results_due [$];

    int           error_count   = 0;
    int           results_seen  = 0;
    int unsigned  cycle_count   = 0;
    int           burst_left    = 0;
    bit           gaps_on       = 1'b1;
    int           random_sent   = 0;
    int           stall_mode    = 0;
    int           stall_left    = 0;

    stack_machine_executor_core #(
        .STACK_DEPTH(STACK_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .instr_valid(instr_valid),
        .instr_stall(instr_stall),
        .cmd(cmd),
        .operand(operand),
        .end_of_program(end_of_program),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .top_value(top_value),
        .stack_depth(stack_depth),
        .status(status),
        .print_strobe(print_strobe),
        .done_res(done_res)
    );

    always #1 clk = ~clk;

    function automatic exec_result_t execute_instr(input cmd_code_t op, input word_t opnd,
                                                   input logic eop);
        exec_result_t       res;
        logic signed [31:0] a;
        logic signed [31:0] b;
        word_t              r;
        bit                 writes_back;
        res.printed = 1'b0;
        if (!halted_model && err_model == ST_OK) begin
            case (op)
                OP_PUSH:
                begin
                    if (sp_model >= STACK_WORDS) begin
                        err_model = ST_OVERFLOW;
                    end else begin
                        stack_mem[sp_model] = opnd;
                        sp_model++;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    if (sp_model < 2) begin
                        err_model = ST_UNDERFLOW;
                    end else begin
                        b = stack_mem[sp_model - 1];
                        a = stack_mem[sp_model - 2];
                        writes_back = 1'b1;
                        r = '0;
                        case (op)
                            OP_ADD: r = a + b;
                            OP_SUB: r = a - b;
                            OP_MUL: r = a * b;
                            default:
                            begin
                                if (b == 0) begin
                                    err_model = ST_DIVZERO;
                                    writes_back = 1'b0;
                                end else if (a == WORD_MIN && b == WORD_NEG1) begin
                                    r = WORD_MIN;
                                end else begin
                                    r = a / b;
                                end
                            end
                        endcase
                        if (writes_back) begin
                            sp_model--;
                            stack_mem[sp_model - 1] = r;
                        end
                    end
                end
                OP_PEEK:
                begin
                    if (sp_model == 0)
                        err_model = ST_UNDERFLOW;
                    else
                        res.printed = 1'b1;
                end
                OP_HALT: halted_model = 1'b1;
                default: err_model = ST_UNKNOWN;
            endcase
        end
        res.top = (sp_model > 0) ? stack_mem[sp_model - 1] : '0;
        res.depth = 9'(sp_model);
        if (err_model != ST_OK)
            res.code = err_model;
        else if (eop && sp_model == 0)
            res.code = ST_UNDERFLOW;
        else if (halted_model)
            res.code = ST_HALTED;
        else
            res.code = ST_OK;
        res.done = eop;
        if (eop) begin
            sp_model = 0;
            halted_model = 1'b0;
            err_model = ST_OK;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
        error_count++;
    endtask

    task automatic send_instr(input cmd_code_t op, input word_t opnd, input logic eop);
        @(negedge clk);
        if (gaps_on && burst_left == 0) begin
            instr_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        cmd <= op;
        operand <= opnd;
        end_of_program <= eop;
        instr_valid <= 1'b1;
        do
            @(posedge clk);
        while (instr_stall);
        results_due.push_back(execute_instr(op, opnd, eop));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        instr_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic word_t pick_operand();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return WORD_NEG1;
            3: return '0;
            4, 5, 6: return word_t'(int'($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_code_t pick_opcode(input bit noisy);
        int roll;
        roll = $urandom_range(0, 99);
        if (noisy)
            return cmd_code_t'($urandom_range(OP_NONE, OP_LAST));
        if (roll < 3)
            return $urandom_range(0, 1) ? OP_NONE
                                        : cmd_code_t'($urandom_range(OP_HALT + 1, OP_LAST));
        if (roll < 5)
            return OP_HALT;
        if (roll < 12)
            return OP_PEEK;
        if (sp_model < 2 && roll < 92)
            return OP_PUSH;
        if (roll < 22)
            return OP_DIV;
        if (roll < 55)
            return OP_PUSH;
        case ($urandom_range(0, 2))
            0: return OP_ADD;
            1: return OP_SUB;
            default: return OP_MUL;
        endcase
    endfunction

    task automatic run_program(input int len, input bit noisy);
        for (int k = 0; k < len; k++) begin
            random_sent++;
            send_instr(pick_opcode(noisy), pick_operand(), k == len - 1);
        end
    endtask

    task automatic test_arithmetic_wrap();
        send_instr(OP_PUSH, WORD_MAX, 1'b0);
        send_instr(OP_PUSH, 32'd1, 1'b0);
        send_instr(OP_ADD, $urandom, 1'b0);
        send_instr(OP_PUSH, 32'd1, 1'b0);
        send_instr(OP_SUB, $urandom, 1'b0);
        send_instr(OP_PUSH, WORD_MAX, 1'b0);
        send_instr(OP_MUL, $urandom, 1'b0);
        send_instr(OP_PEEK, $urandom, 1'b1);
    endtask

    task automatic test_division();
        send_instr(OP_PUSH, WORD_MIN, 1'b0);
        send_instr(OP_PUSH, WORD_NEG1, 1'b0);
        send_instr(OP_DIV, '0, 1'b0);
        send_instr(OP_PUSH, -32'sd7, 1'b0);
        send_instr(OP_PUSH, 32'sd2, 1'b0);
        send_instr(OP_DIV, '0, 1'b1);
    endtask

    task automatic test_faults();
        send_instr(OP_PUSH, 32'd5, 1'b0);
        send_instr(OP_PUSH, '0, 1'b0);
        send_instr(OP_DIV, '0, 1'b0);
        send_instr(OP_HALT, '0, 1'b1);
        send_instr(OP_ADD, '0, 1'b1);
        send_instr(OP_PEEK, '0, 1'b1);
        send_instr(OP_NONE, '0, 1'b0);
        send_instr(OP_LAST, WORD_NEG1, 1'b1);
    endtask

    task automatic test_halt_and_end();
        send_instr(OP_PUSH, 32'd4, 1'b0);
        send_instr(OP_HALT, '0, 1'b0);
        send_instr(OP_PUSH, 32'd9, 1'b1);
        send_instr(OP_HALT, '0, 1'b1);
    endtask

    task automatic test_stack_full();
        for (int k = 0; k < STACK_WORDS; k++)
            send_instr(OP_PUSH, $urandom, 1'b0);
        send_instr(OP_PEEK, '0, 1'b0);
        send_instr(OP_ADD, '0, 1'b0);
        send_instr(OP_PUSH, pick_operand(), 1'b0);
        send_instr(OP_PUSH, pick_operand(), 1'b0);
        send_instr(OP_PEEK, '0, 1'b0);
        send_instr(OP_PUSH, pick_operand(), 1'b1);
    endtask

    task automatic test_random_programs();
        int programs;
        programs = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) == 0)
                run_program($urandom_range(1, 6), 1'b1);
            else
                run_program($urandom_range(1, 40), 1'b0);
            programs++;
            if (programs % 40 == 0)
                wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 128);
        end
        stall_left--;
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            2: res_stall <= ($urandom_range(0, 3) != 0);
            default: res_stall <= (cycle_count % 3 == 0);
        endcase
    end

    always @(posedge clk) begin
        exec_result_t want;
        if (rst_n && res_valid && !res_stall) begin
            if (results_due.size() == 0) begin
                report_mismatch("transfer with nothing pending", top_value, '0);
            end else begin
                want = results_due.pop_front();
                if (top_value !== want.top)
                    report_mismatch("top_value", top_value, want.top);
                if (stack_depth !== want.depth)
                    report_mismatch("stack_depth", stack_depth, want.depth);
                if (status !== want.code)
                    report_mismatch("status", status, want.code);
                if (print_strobe !== want.printed)
                    report_mismatch("print_strobe", print_strobe, want.printed);
                if (done_res !== want.done)
                    report_mismatch("done_res", done_res, want.done);
            end
            results_seen++;
        end
    end

    initial begin
        for (int k = 0; k < STACK_WORDS; k++)
            stack_mem[k] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_arithmetic_wrap();
        test_division();
        test_faults();
        test_halt_and_end();
        test_stack_full();
        test_random_programs();
        wait_drained();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
